### rtl/core/qrbi_pkg.sv
// Shared constants and types for the queue with remove-by-id block.
`default_nettype none

package qrbi_pkg;

   // default number of record slots
   localparam int DEPTH_DEF = 16;

   // field widths
   localparam int KIND_W   = 2;
   localparam int ID_W     = 16;
   localparam int PAY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - (ID_W + PAY_W + COUNT_W + 1);

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_PUSH_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

   // one request transaction
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   rec_id;
      logic [PAY_W-1:0]  rec_payload;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_id;
      logic [PAY_W-1:0]    out_payload;
      logic [COUNT_W-1:0]  entry_count;
      logic                is_empty;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/qrbi_store.sv
// Record and link memories with registered read data.
`default_nettype none

module qrbi_store #(
   parameter int DEPTH = qrbi_pkg::DEPTH_DEF
) (
   input  wire logic                      clock,
   // shared read address for both memories
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [qrbi_pkg::ID_W-1:0]      rd_id,
   output logic [qrbi_pkg::PAY_W-1:0]     rd_pay,
   output logic [$clog2(DEPTH)-1:0]       rd_link,
   // record write port
   input  wire logic                      rec_we,
   input  wire logic [$clog2(DEPTH)-1:0]  rec_addr,
   input  wire logic [qrbi_pkg::ID_W-1:0] rec_id_wr,
   input  wire logic [qrbi_pkg::PAY_W-1:0] rec_pay_wr,
   // link write port
   input  wire logic                      link_we,
   input  wire logic [$clog2(DEPTH)-1:0]  link_addr,
   input  wire logic [$clog2(DEPTH)-1:0]  link_data
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int REC_W  = qrbi_pkg::ID_W + qrbi_pkg::PAY_W;

   logic [REC_W-1:0]  rec_mem [DEPTH];
   logic [SLOT_W-1:0] link_mem [DEPTH];
   logic [REC_W-1:0]  rec_rd_ff;
   logic [SLOT_W-1:0] link_rd_ff;

   // record memory: id and payload of each slot
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_addr] <= {rec_id_wr, rec_pay_wr};
      end
      rec_rd_ff <= rec_mem[rd_addr];
   end

   // link memory: next slot in list order
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_addr] <= link_data;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   assign rd_id   = rec_rd_ff[REC_W-1 -: qrbi_pkg::ID_W];
   assign rd_pay  = rec_rd_ff[qrbi_pkg::PAY_W-1:0];
   assign rd_link = link_rd_ff;

endmodule

`default_nettype wire

### rtl/core/qrbi_seq.sv
// Sequencer: free-slot scan, list walk with one id compare per cycle, unlink.
`default_nettype none

module qrbi_seq #(
   parameter int DEPTH = qrbi_pkg::DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request side
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire qrbi_pkg::req_type          req,
   // result side
   output logic                            res_valid,
   input  wire logic                       res_take,
   output qrbi_pkg::rsp_type               res,
   // memory interface
   output logic [$clog2(DEPTH)-1:0]        rd_addr,
   input  wire logic [qrbi_pkg::ID_W-1:0]  rd_id,
   input  wire logic [qrbi_pkg::PAY_W-1:0] rd_pay,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_link,
   output logic                            rec_we,
   output logic [$clog2(DEPTH)-1:0]        rec_addr,
   output logic [qrbi_pkg::ID_W-1:0]       rec_id_wr,
   output logic [qrbi_pkg::PAY_W-1:0]      rec_pay_wr,
   output logic                            link_we,
   output logic [$clog2(DEPTH)-1:0]        link_addr,
   output logic [$clog2(DEPTH)-1:0]        link_data
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WALK,
      ST_DONE
   } state_type;

   // control state
   state_type                     state_ff, state_in;
   logic [DEPTH-1:0]              used_ff, used_in;
   logic [SLOT_W-1:0]             head_ff, head_in;
   logic [SLOT_W-1:0]             tail_ff, tail_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   // per-operation working registers
   logic [SLOT_W-1:0]             cur_ff, cur_in;
   logic [SLOT_W-1:0]             prev_ff, prev_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [qrbi_pkg::KIND_W-1:0]   op_ff, op_in;
   logic [qrbi_pkg::ID_W-1:0]     id_ff, id_in;
   logic [qrbi_pkg::PAY_W-1:0]    pay_ff, pay_in;
   logic [qrbi_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [qrbi_pkg::ID_W-1:0]     out_id_ff, out_id_in;
   logic [qrbi_pkg::PAY_W-1:0]    out_pay_ff, out_pay_in;

   logic                          hit;
   logic [CNT_W-1:0]              idx_nxt;

   // shared compare unit: pop takes the first entry, remove matches the id
   assign hit     = (op_ff == qrbi_pkg::KIND_POP) || (rd_id == id_ff);
   assign idx_nxt = idx_ff + CNT_W'(1);

   // next-state logic
   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      idx_in     = idx_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      pay_in     = pay_ff;
      status_in  = status_ff;
      out_id_in  = out_id_ff;
      out_pay_in = out_pay_ff;
      rd_addr    = head_ff;
      rec_we     = 1'b0;
      rec_addr   = cur_ff;
      rec_id_wr  = id_ff;
      rec_pay_wr = pay_ff;
      link_we    = 1'b0;
      link_addr  = tail_ff;
      link_data  = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req.kind;
               id_in      = req.rec_id;
               pay_in     = req.rec_payload;
               status_in  = qrbi_pkg::STAT_DONE;
               out_id_in  = '0;
               out_pay_in = '0;
               idx_in     = '0;
               cur_in     = head_ff;
               case (req.kind)
                  qrbi_pkg::KIND_PUSH: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = qrbi_pkg::STAT_PUSH_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        cur_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  qrbi_pkg::KIND_POP: begin
                     if (count_ff == '0) begin
                        status_in = qrbi_pkg::STAT_POP_EMPTY;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  qrbi_pkg::KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = qrbi_pkg::STAT_NOT_FOUND;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     // unused code: no change
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // look for a free slot, one per cycle
         ST_SCAN: begin
            if (!used_ff[cur_ff]) begin
               rec_we = 1'b1;
               if (count_ff != '0) begin
                  link_we = 1'b1;
               end else begin
                  head_in = cur_ff;
               end
               tail_in         = cur_ff;
               used_in[cur_ff] = 1'b1;
               count_in        = count_ff + CNT_W'(1);
               state_in        = ST_DONE;
            end else begin
               cur_in = cur_ff + SLOT_W'(1);
            end
         end

         // read data for cur_ff is present this cycle
         ST_WALK: begin
            if (hit) begin
               out_id_in  = rd_id;
               out_pay_in = rd_pay;
               if (count_ff != CNT_W'(1)) begin
                  if (cur_ff == head_ff) begin
                     head_in = rd_link;
                  end else begin
                     link_we   = 1'b1;
                     link_addr = prev_ff;
                     link_data = rd_link;
                     if (cur_ff == tail_ff) begin
                        tail_in = prev_ff;
                     end
                  end
               end
               used_in[cur_ff] = 1'b0;
               count_in        = count_ff - CNT_W'(1);
               state_in        = ST_DONE;
            end else if (idx_nxt == count_ff) begin
               status_in = qrbi_pkg::STAT_NOT_FOUND;
               state_in  = ST_DONE;
            end else begin
               idx_in  = idx_nxt;
               prev_in = cur_ff;
               cur_in  = rd_link;
               rd_addr = rd_link;
            end
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      idx_ff     <= idx_in;
      op_ff      <= op_in;
      id_ff      <= id_in;
      pay_ff     <= pay_in;
      status_ff  <= status_in;
      out_id_ff  <= out_id_in;
      out_pay_ff <= out_pay_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   // result fields
   always_comb begin
      res.status      = status_ff;
      res.out_id      = out_id_ff;
      res.out_payload = out_pay_ff;
      res.entry_count = qrbi_pkg::COUNT_W'(count_ff);
      res.is_empty    = (count_ff == '0);
   end

endmodule

`default_nettype wire

### rtl/core/queue_with_remove_by_id.sv
// Top level: bounded record queue with push, pop and remove by identifier.
//
//   channel  dir  ports                     contents
//   req      in   req_tvalid/tready/tdata   tdata: rec_id, rec_payload; tuser: kind
//   rsp      out  rsp_tvalid/tready/tdata   tdata: out_id, out_payload, entry_count,
//                                           is_empty; tuser: status
//
// Operation steps: push runs the free-slot scan, checking k = 1..DEPTH slots;
// pop unlinks the head entry; remove walks n = 1..DEPTH entries in list order,
// one link-memory read and id compare per cycle. Rejected operations go straight to the result.
// Reset is synchronous; the list comes up empty, no memory clearing.
// A finished result waits in the output register while the next request is taken;
// the sequencer holds its result when that register is still occupied.
`default_nettype none

module queue_with_remove_by_id #(
   parameter int DEPTH = qrbi_pkg::DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [15:0] rec_id, [47:16] rec_payload
   input  wire logic [qrbi_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] kind
   input  wire logic [qrbi_pkg::KIND_W-1:0]      req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [15:0] out_id, [47:16] out_payload, [52:48] entry_count, [53] is_empty
   output logic [qrbi_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [1:0] status
   output logic [qrbi_pkg::STATUS_W-1:0]         rsp_tuser
);

   localparam int SLOT_W = $clog2(DEPTH);

   qrbi_pkg::req_type           req;
   qrbi_pkg::rsp_type           res;
   logic                        res_valid;
   logic                        res_take;
   logic [SLOT_W-1:0]           rd_addr;
   logic [qrbi_pkg::ID_W-1:0]   rd_id;
   logic [qrbi_pkg::PAY_W-1:0]  rd_pay;
   logic [SLOT_W-1:0]           rd_link;
   logic                        rec_we;
   logic [SLOT_W-1:0]           rec_addr;
   logic [qrbi_pkg::ID_W-1:0]   rec_id_wr;
   logic [qrbi_pkg::PAY_W-1:0]  rec_pay_wr;
   logic                        link_we;
   logic [SLOT_W-1:0]           link_addr;
   logic [SLOT_W-1:0]           link_data;

   logic                        rsp_valid_ff, rsp_valid_in;
   qrbi_pkg::rsp_type           rsp_data_ff;

   // unpack request
   always_comb begin
      req.kind        = req_tuser;
      req.rec_id      = req_tdata[qrbi_pkg::ID_W-1:0];
      req.rec_payload = req_tdata[qrbi_pkg::ID_W +: qrbi_pkg::PAY_W];
   end

   qrbi_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res),
      .rd_addr    (rd_addr),
      .rd_id      (rd_id),
      .rd_pay     (rd_pay),
      .rd_link    (rd_link),
      .rec_we     (rec_we),
      .rec_addr   (rec_addr),
      .rec_id_wr  (rec_id_wr),
      .rec_pay_wr (rec_pay_wr),
      .link_we    (link_we),
      .link_addr  (link_addr),
      .link_data  (link_data)
   );

   qrbi_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .rd_id      (rd_id),
      .rd_pay     (rd_pay),
      .rd_link    (rd_link),
      .rec_we     (rec_we),
      .rec_addr   (rec_addr),
      .rec_id_wr  (rec_id_wr),
      .rec_pay_wr (rec_pay_wr),
      .link_we    (link_we),
      .link_addr  (link_addr),
      .link_data  (link_data)
   );

   // output register: load when empty or being drained
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   // pack result
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {{qrbi_pkg::RSP_PAD_W{1'b0}},
                        rsp_data_ff.is_empty,
                        rsp_data_ff.entry_count,
                        rsp_data_ff.out_payload,
                        rsp_data_ff.out_id};

endmodule

`default_nettype wire
